// File: sv/assert_macros.svh
// Assertion macros shared by the smearing-matrix entry RTL.
// Needs nothing else; files that assert take it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: sv/grm_pkg.sv
// Package for the Gaussian resolution matrix entry unit: item types, constants.
// Used by every module of the block; depends on nothing.
`default_nettype none
package grm_pkg;

	localparam int BIN_INDEX_COUNT = 1024;
	localparam logic [9:0] BIN_MASK = 10'(BIN_INDEX_COUNT - 1);

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_STOCHASTIC  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SQRT_ENERGY = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_NOISE       = 2'd2;

	localparam logic [23:0] LN2_Q24        = 24'd11629080;
	localparam logic [31:0] SQRT2PI_Q30    = 32'd2691471616;
	localparam logic [47:0] KEEP_THRESHOLD = 48'd1760;
	localparam logic [47:0] PROB_MAX       = '1;
	localparam logic [30:0] U_CAP          = 31'h4000_0000;

	localparam int SQRT_STEPS  = 32;
	localparam int U_FRAC_BITS = 30;
	localparam int RANGE_STEPS = 7;
	localparam int EXP_TERMS   = 14;
	localparam int RECIP_SHIFT = 42;
	localparam int QUOT_BITS   = 74;

	typedef struct packed {
		logic [31:0] true_low_edge;
		logic [31:0] true_high_edge;
		logic [31:0] rec_low_edge;
		logic [31:0] rec_high_edge;
		logic [9:0]  true_bin;
		logic [9:0]  rec_bin;
	} req_t;

	typedef struct packed {
		logic [47:0] probability;
		logic        keep;
		logic        status;
		logic [9:0]  out_true_bin;
		logic [9:0]  out_rec_bin;
	} rsp_t;

	typedef struct packed {
		logic [31:0] stochastic_term;
		logic [31:0] sqrt_energy_term;
		logic [31:0] noise_term;
	} cfg_t;

	typedef struct packed {
		logic [31:0] w;
		logic [9:0]  true_bin;
		logic [9:0]  rec_bin;
	} tag_t;

	typedef struct packed {
		logic [63:0] dd;
		logic [62:0] variance;
		logic        status;
		tag_t        tag;
	} front_t;

	typedef struct packed {
		logic [30:0] u;
		logic [31:0] sigma;
		logic        status;
		tag_t        tag;
	} core_t;

	typedef struct packed {
		logic [32:0] e;
		logic [6:0]  k;
		logic [31:0] sigma;
		logic        status;
		tag_t        tag;
	} exp_t;

endpackage
`default_nettype wire

// File: sv/gaussian_resolution_matrix_entry_unit.sv
// Gaussian resolution matrix entry unit: one smearing-matrix entry per item.
// Stages: 4 front stages, 32 square-root and quotient stages, 64 stages of range
// reduction, series and rounding, and 76 output-divide stages.
// Throughput is one item per cycle; a stalled result freezes the whole pipeline in place.
// Reset clears all valid bits and the three coefficient registers to zero.
`default_nettype none
module gaussian_resolution_matrix_entry_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire grm_pkg::req_t                     req_item,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output grm_pkg::rsp_t                          rsp_item,
	input  wire logic                              cfg_write,
	input  wire logic [grm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [31:0]                       cfg_data
);

	grm_pkg::cfg_t   cfg_q;
	logic            en;

	logic            front_valid, core_valid, exp_valid;
	grm_pkg::front_t front_item;
	grm_pkg::core_t  core_item;
	grm_pkg::exp_t   exp_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				grm_pkg::CFG_STOCHASTIC:  cfg_q.stochastic_term  <= cfg_data;
				grm_pkg::CFG_SQRT_ENERGY: cfg_q.sqrt_energy_term <= cfg_data;
				grm_pkg::CFG_NOISE:       cfg_q.noise_term       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Every stage advances together unless the held result is being stalled.
	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	grm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (req_valid),
		.src_item  (req_item),
		.cfg       (cfg_q),
		.res_valid (front_valid),
		.res_item  (front_item)
	);

	grm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (front_valid),
		.src_item  (front_item),
		.res_valid (core_valid),
		.res_item  (core_item)
	);

	grm_exp u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (core_valid),
		.src_item  (core_item),
		.res_valid (exp_valid),
		.res_item  (exp_item)
	);

	grm_outdiv u_outdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (exp_valid),
		.src_item  (exp_item),
		.res_valid (rsp_valid),
		.res_item  (rsp_item)
	);

endmodule
`default_nettype wire

// File: sv/grm_front.sv
// Front end: bin centres, width, squared distance and variance, four stages.
// Depends on grm_pkg.
`default_nettype none
module grm_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          src_valid,
	input  wire grm_pkg::req_t src_item,
	input  wire grm_pkg::cfg_t cfg,
	output logic               res_valid,
	output grm_pkg::front_t    res_item
);

	logic v_s1, v_s2, v_s3, v_s4;

	logic [31:0] et_s1, er_s1, bb_s1;
	logic [45:0] cc_s1;
	grm_pkg::tag_t tag_s1, tag_s2, tag_s3;

	logic [31:0] ae_s2, d_s2;
	logic [53:0] bet_s2, bet_s3;
	logic [45:0] cc_s2, cc_s3;
	logic        etz_s2, etz_s3;

	logic [61:0] aa_s3;
	logic [63:0] dd_s3;

	grm_pkg::front_t out_s4;

	logic [32:0] tsum, rsum;
	logic [63:0] bb_p, cc_p, ae_p, bet_p, aa_p, dd_p;
	logic [62:0] var_sum;

	always_comb begin
		tsum    = {1'b0, src_item.true_low_edge} + {1'b0, src_item.true_high_edge};
		rsum    = {1'b0, src_item.rec_low_edge} + {1'b0, src_item.rec_high_edge};
		bb_p    = 64'(cfg.sqrt_energy_term) * 64'(cfg.sqrt_energy_term);
		cc_p    = 64'(cfg.noise_term) * 64'(cfg.noise_term);
		ae_p    = 64'(cfg.stochastic_term) * 64'(et_s1);
		bet_p   = 64'(bb_s1) * 64'(et_s1);
		aa_p    = 64'(ae_s2) * 64'(ae_s2);
		dd_p    = 64'(d_s2) * 64'(d_s2);
		var_sum = {1'b0, aa_s3} + {9'b0, bet_s3} + {17'b0, cc_s3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= src_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			et_s1 <= tsum[32:1];
			er_s1 <= rsum[32:1];
			bb_s1 <= bb_p[63:32];
			cc_s1 <= cc_p[63:18];
			// An inverted true bin counts as empty.
			tag_s1.w <= (src_item.true_high_edge >= src_item.true_low_edge) ?
				src_item.true_high_edge - src_item.true_low_edge : 32'd0;
			tag_s1.true_bin <= src_item.true_bin & grm_pkg::BIN_MASK;
			tag_s1.rec_bin  <= src_item.rec_bin & grm_pkg::BIN_MASK;

			ae_s2  <= ae_p[63:32];
			bet_s2 <= bet_p[63:10];
			d_s2   <= (et_s1 >= er_s1) ? et_s1 - er_s1 : er_s1 - et_s1;
			cc_s2  <= cc_s1;
			etz_s2 <= (et_s1 == 32'd0);
			tag_s2 <= tag_s1;

			aa_s3  <= aa_p[63:2];
			dd_s3  <= dd_p;
			bet_s3 <= bet_s2;
			cc_s3  <= cc_s2;
			etz_s3 <= etz_s2;
			tag_s3 <= tag_s2;

			out_s4.dd       <= dd_s3;
			out_s4.variance <= var_sum;
			out_s4.status   <= etz_s3 || (var_sum == 63'd0);
			out_s4.tag      <= tag_s3;
		end
	end

	assign res_valid = v_s4;
	assign res_item  = out_s4;

endmodule
`default_nettype wire

// File: sv/grm_core.sv
// Square root of the variance and the scaled quotient u = d^2/(2 sigma^2), one radix-2
// root step per stage and, after an overflow check, one quotient bit per stage. Depends on grm_pkg.
`default_nettype none
module grm_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            src_valid,
	input  wire grm_pkg::front_t src_item,
	output logic                 res_valid,
	output grm_pkg::core_t       res_item
);

	localparam int Steps = grm_pkg::SQRT_STEPS;
	localparam int FracBits = grm_pkg::U_FRAC_BITS;

	typedef struct packed {
		logic [63:0]         rad;
		logic [34:0]         rem_sq;
		logic [31:0]         root;
		logic [62:0]         variance;
		logic [62:0]         drem;
		logic [FracBits-1:0] nbits;
		logic [FracBits-1:0] q;
		logic                cap;
		logic                status;
		grm_pkg::tag_t       tag;
	} stage_t;

	stage_t     stage0;
	stage_t     st_s [1:Steps];
	logic [Steps:1] v_s;

	always_comb begin
		stage0.rad      = {1'b0, src_item.variance};
		stage0.rem_sq   = '0;
		stage0.root     = '0;
		stage0.variance = src_item.variance;
		// The quotient stays below 2^30 unless the high part already reaches the divisor.
		stage0.drem     = {8'b0, src_item.dd[63:9]};
		stage0.nbits    = {src_item.dd[8:0], 21'b0};
		stage0.q        = '0;
		stage0.cap      = 1'b0;
		stage0.status   = src_item.status;
		stage0.tag      = src_item.tag;
	end

	for (genvar j = 0; j < Steps; j++) begin : g_step
		stage_t cur, nxt;
		logic   vcur;

		if (j == 0) begin : g_first
			assign cur  = stage0;
			assign vcur = src_valid;
		end else begin : g_rest
			assign cur  = st_s[j];
			assign vcur = v_s[j];
		end

		always_comb begin
			logic [34:0] t;
			logic [34:0] trial;
			logic [63:0] t2;
			nxt   = cur;
			t     = {cur.rem_sq[32:0], cur.rad[63:62]};
			trial = {1'b0, cur.root, 2'b01};
			if (t >= trial) begin
				nxt.rem_sq = t - trial;
				nxt.root   = {cur.root[30:0], 1'b1};
			end else begin
				nxt.rem_sq = t;
				nxt.root   = {cur.root[30:0], 1'b0};
			end
			nxt.rad = {cur.rad[61:0], 2'b00};
			t2 = {cur.drem, cur.nbits[FracBits-1]};
			if (j == 0) begin
				nxt.cap = (cur.drem >= cur.variance);
			end else if (j <= FracBits) begin
				if (t2 >= {1'b0, cur.variance}) begin
					nxt.drem = 63'(t2 - {1'b0, cur.variance});
					nxt.q    = {cur.q[FracBits-2:0], 1'b1};
				end else begin
					nxt.drem = t2[62:0];
					nxt.q    = {cur.q[FracBits-2:0], 1'b0};
				end
				nxt.nbits = {cur.nbits[FracBits-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= vcur;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[j+1] <= nxt;
			end
		end
	end

	assign res_valid      = v_s[Steps];
	assign res_item.u     = st_s[Steps].cap ? grm_pkg::U_CAP : {1'b0, st_s[Steps].q};
	assign res_item.sigma = st_s[Steps].root;
	assign res_item.status = st_s[Steps].status;
	assign res_item.tag   = st_s[Steps].tag;

endmodule
`default_nettype wire

// File: sv/grm_exp.sv
// Range reduction u = k*ln2 + r and exp(-r) by a 14-term series,
// four stages per term plus a rounding stage. Depends on grm_pkg.
`default_nettype none
module grm_exp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           src_valid,
	input  wire grm_pkg::core_t src_item,
	output logic                res_valid,
	output grm_pkg::exp_t       res_item
);

	localparam int RSteps = grm_pkg::RANGE_STEPS;
	localparam int SSteps = 4 * grm_pkg::EXP_TERMS;

	typedef struct packed {
		logic [30:0]   r;
		logic [6:0]    k;
		logic [31:0]   sigma;
		logic          status;
		grm_pkg::tag_t tag;
	} red_t;

	typedef struct packed {
		logic [40:0]   term;
		logic [39:0]   x;
		logic [62:0]   pl;
		logic [62:0]   ph;
		logic [39:0]   q0;
		logic [41:0]   even;
		logic [41:0]   odd;
		logic [23:0]   r;
		logic [6:0]    k;
		logic [31:0]   sigma;
		logic          status;
		grm_pkg::tag_t tag;
	} ser_t;

	red_t red0;
	red_t red_s [1:RSteps];
	logic [RSteps:1] vr_s;

	ser_t ser0;
	ser_t ser_s [1:SSteps];
	logic [SSteps:1] vs_s;

	grm_pkg::exp_t out_s;
	logic          vout_s;

	always_comb begin
		red0.r      = src_item.u;
		red0.k      = '0;
		red0.sigma  = src_item.sigma;
		red0.status = src_item.status;
		red0.tag    = src_item.tag;
	end

	for (genvar j = 0; j < RSteps; j++) begin : g_red
		localparam int BitPos = RSteps - 1 - j;
		localparam logic [30:0] Lim = 31'(64'(grm_pkg::LN2_Q24) << BitPos);
		red_t cur, nxt;
		logic vcur;

		if (j == 0) begin : g_first
			assign cur  = red0;
			assign vcur = src_valid;
		end else begin : g_rest
			assign cur  = red_s[j];
			assign vcur = vr_s[j];
		end

		always_comb begin
			nxt = cur;
			if (cur.r >= Lim) begin
				nxt.r         = cur.r - Lim;
				nxt.k[BitPos] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vr_s[j+1] <= 1'b0;
			end else if (en) begin
				vr_s[j+1] <= vcur;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				red_s[j+1] <= nxt;
			end
		end
	end

	always_comb begin
		ser0        = '0;
		ser0.term   = 41'h100_0000_0000;
		ser0.even   = 42'h100_0000_0000;
		ser0.r      = red_s[RSteps].r[23:0];
		ser0.k      = red_s[RSteps].k;
		ser0.sigma  = red_s[RSteps].sigma;
		ser0.status = red_s[RSteps].status;
		ser0.tag    = red_s[RSteps].tag;
	end

	// Each term: multiply by r, reciprocal partial products, sum, one-step correction.
	for (genvar g = 0; g < grm_pkg::EXP_TERMS; g++) begin : g_term
		localparam int StepN = g + 1;
		localparam logic [42:0] Recip = 43'((64'd1 << grm_pkg::RECIP_SHIFT) / StepN);

		for (genvar p = 0; p < 4; p++) begin : g_phase
			localparam int Idx = 4 * g + p;
			ser_t cur, nxt;
			logic vcur;

			if (Idx == 0) begin : g_first
				assign cur  = ser0;
				assign vcur = vr_s[RSteps];
			end else begin : g_rest
				assign cur  = ser_s[Idx];
				assign vcur = vs_s[Idx];
			end

			if (p == 0) begin : g_mul
				always_comb begin
					logic [63:0] prod;
					nxt   = cur;
					prod  = 64'(cur.term) * 64'(cur.r);
					nxt.x = prod[63:24];
				end
			end else if (p == 1) begin : g_recip
				always_comb begin
					nxt    = cur;
					nxt.pl = 63'(cur.x[19:0]) * 63'(Recip);
					nxt.ph = 63'(cur.x[39:20]) * 63'(Recip);
				end
			end else if (p == 2) begin : g_sum
				always_comb begin
					logic [82:0] s;
					nxt    = cur;
					s      = {cur.ph, 20'b0} + {20'b0, cur.pl};
					nxt.q0 = s[81:42];
				end
			end else begin : g_fix
				always_comb begin
					logic [43:0] prod_n;
					logic [43:0] rem;
					logic [40:0] term_n;
					nxt    = cur;
					prod_n = 44'(cur.q0) * 44'(StepN);
					rem    = {4'b0, cur.x} - prod_n;
					// The reciprocal estimate is low by at most one.
					term_n = (rem >= 44'(StepN)) ? 41'(cur.q0) + 41'd1 : 41'(cur.q0);
					nxt.term = term_n;
					if (StepN % 2 == 1) begin
						nxt.odd = cur.odd + 42'(term_n);
					end else begin
						nxt.even = cur.even + 42'(term_n);
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vs_s[Idx+1] <= 1'b0;
				end else if (en) begin
					vs_s[Idx+1] <= vcur;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					ser_s[Idx+1] <= nxt;
				end
			end
		end
	end

	logic [41:0] diff, rnd;

	always_comb begin
		diff = ser_s[SSteps].even - ser_s[SSteps].odd;
		rnd  = diff + 42'd128;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout_s <= 1'b0;
		end else if (en) begin
			vout_s <= vs_s[SSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s.e      <= rnd[40:8];
			out_s.k      <= ser_s[SSteps].k;
			out_s.sigma  <= ser_s[SSteps].sigma;
			out_s.status <= ser_s[SSteps].status;
			out_s.tag    <= ser_s[SSteps].tag;
		end
	end

	assign res_valid = vout_s;
	assign res_item  = out_s;

endmodule
`default_nettype wire

// File: sv/grm_outdiv.sv
// Product stage, then density quotient W*e*2^41/(sigma*sqrt(2pi)), one quotient bit per stage,
// then the shift by k, zeroing on status, saturation, keep flag and the output register.
// Depends on grm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module grm_outdiv (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          src_valid,
	input  wire grm_pkg::exp_t src_item,
	output logic               res_valid,
	output grm_pkg::rsp_t      res_item
);

	localparam int QBits = grm_pkg::QUOT_BITS;

	typedef struct packed {
		logic [63:0]   num;
		logic [62:0]   den;
		logic [6:0]    k;
		logic          status;
		grm_pkg::tag_t tag;
	} mul_t;

	typedef struct packed {
		logic [62:0]      rem;
		logic [62:0]      den;
		logic [QBits-1:0] nbits;
		logic [QBits-1:0] q;
		logic [6:0]       k;
		logic             status;
		grm_pkg::tag_t    tag;
	} div_t;

	mul_t mul_s1;
	logic v_mul_s1;
	div_t div0;
	div_t div_s [1:QBits];
	logic [QBits:1] vd_s;

	grm_pkg::rsp_t rsp_s;
	logic          vout_s;

	logic [64:0] num_p;
	logic [63:0] den_p;

	always_comb begin
		num_p = 65'(src_item.tag.w) * 65'(src_item.e);
		den_p = 64'(src_item.sigma) * 64'(grm_pkg::SQRT2PI_Q30);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_mul_s1 <= 1'b0;
		end else if (en) begin
			v_mul_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_s1.num    <= num_p[63:0];
			mul_s1.den    <= den_p[62:0];
			mul_s1.k      <= src_item.k;
			mul_s1.status <= src_item.status;
			mul_s1.tag    <= src_item.tag;
		end
	end

	// Unless sigma is zero, the divisor is at least 2^31, so the top 31 numerator bits never reach it.
	always_comb begin
		div0.rem    = {32'b0, mul_s1.num[63:33]};
		div0.den    = mul_s1.den;
		div0.nbits  = {mul_s1.num[32:0], 41'b0};
		div0.q      = '0;
		div0.k      = mul_s1.k;
		div0.status = mul_s1.status;
		div0.tag    = mul_s1.tag;
	end

	for (genvar j = 0; j < QBits; j++) begin : g_div
		div_t cur, nxt;
		logic vcur;

		if (j == 0) begin : g_first
			assign cur  = div0;
			assign vcur = v_mul_s1;
		end else begin : g_rest
			assign cur  = div_s[j];
			assign vcur = vd_s[j];
		end

		always_comb begin
			logic [63:0] t;
			nxt = cur;
			t   = {cur.rem, cur.nbits[QBits-1]};
			if (t >= {1'b0, cur.den}) begin
				nxt.rem = 63'(t - {1'b0, cur.den});
				nxt.q   = {cur.q[QBits-2:0], 1'b1};
			end else begin
				nxt.rem = t[62:0];
				nxt.q   = {cur.q[QBits-2:0], 1'b0};
			end
			nxt.nbits = {cur.nbits[QBits-2:0], 1'b0};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_s[j+1] <= 1'b0;
			end else if (en) begin
				vd_s[j+1] <= vcur;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[j+1] <= nxt;
			end
		end
	end

	logic [QBits-1:0] shifted;
	logic [47:0]      prob;

	always_comb begin
		shifted = div_s[QBits].q >> div_s[QBits].k;
		if (div_s[QBits].status) begin
			prob = '0;
		end else if (|shifted[QBits-1:48]) begin
			prob = grm_pkg::PROB_MAX;
		end else begin
			prob = shifted[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout_s <= 1'b0;
		end else if (en) begin
			vout_s <= vd_s[QBits];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_s.probability  <= prob;
			rsp_s.keep         <= (prob >= grm_pkg::KEEP_THRESHOLD);
			rsp_s.status       <= div_s[QBits].status;
			rsp_s.out_true_bin <= div_s[QBits].tag.true_bin;
			rsp_s.out_rec_bin  <= div_s[QBits].tag.rec_bin;
		end
	end

	assign res_valid = vout_s;
	assign res_item  = rsp_s;

	`ASSERT_IMPLIES(a_status_zero, clk, arst_n, vout_s && rsp_s.status,
		rsp_s.probability == 48'd0 && !rsp_s.keep)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, !en, $stable(vout_s) && $stable(rsp_s))
	`ASSERT_NEXT(a_mul_hold, clk, arst_n, !en, $stable(v_mul_s1) && $stable(mul_s1))

endmodule
`default_nettype wire
